@@ hdl/free_list_heap_allocator_unit_assert.svh @@
// Assertion macros for the free-list heap allocator.
// Depends on signals named clk and arst_n in the including module.
`ifndef FREE_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FHAL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FHAL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fhal_pkg.sv @@
// Shared types and constants for the free-list heap allocator.
// No dependencies.
package fhal_pkg;

	localparam int OFF_W   = 14;
	localparam int SIZE_W  = 14;
	// Widest dividend seen by the unit-count divider (size plus rounding).
	localparam int DIVIN_W = 15;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef struct packed {
		logic              action;
		logic [SIZE_W-1:0] size_bytes;
		logic [OFF_W-1:0]  block_offset;
	} fhal_req_t;

	typedef struct packed {
		logic [OFF_W-1:0] result_offset;
		logic             granted;
	} fhal_rsp_t;

	// Classified command passed from the front end to the engine.
	typedef enum logic [1:0] {
		KIND_ALLOC,
		KIND_RELEASE,
		KIND_IGNORE
	} fhal_kind_t;

endpackage

@@ hdl/fhal_front.sv @@
// Front end: accepts request transactions, converts bytes to units and classifies them.
// Depends on fhal_pkg.
module fhal_front import fhal_pkg::*; #(
	parameter int HEAP_BYTES = 16384,
	parameter int UNIT_BYTES = 8,
	parameter int ARG_W      = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  fhal_req_t        req,
	output logic             cmd_valid,
	input  logic             cmd_full,
	output logic [ARG_W+1:0] cmd_data
);

	localparam int NUNITS  = HEAP_BYTES / UNIT_BYTES;
	localparam int DIV_SH  = DIVIN_W + $clog2(UNIT_BYTES);
	localparam int RECIP   = (2**DIV_SH + UNIT_BYTES - 1) / UNIT_BYTES;
	localparam int RECIP_W = DIV_SH - 2;
	localparam int PROD_W  = DIVIN_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - DIV_SH;

	logic [DIVIN_W-1:0] dividend;
	logic [PROD_W-1:0]  product;
	logic [QUOT_W-1:0]  quot;
	logic [QUOT_W-1:0]  bp;
	fhal_kind_t         kind;
	logic [ARG_W-1:0]   arg;
	logic               take;

	logic               s1_valid_q;
	fhal_kind_t         kind_s1;
	logic [ARG_W-1:0]   arg_s1;

	// Divide by the unit size with a reciprocal multiply; exact for all dividends.
	always_comb begin
		if (req.action == ACT_RELEASE) begin
			dividend = DIVIN_W'(req.block_offset);
		end else begin
			dividend = DIVIN_W'(req.size_bytes) + DIVIN_W'(UNIT_BYTES - 1);
		end
		product = PROD_W'(dividend) * PROD_W'(RECIP);
		quot    = product[PROD_W-1:DIV_SH];
		bp      = quot - QUOT_W'(1);
	end

	// Classify the transaction and form its argument.
	always_comb begin
		if (req.action == ACT_ALLOC) begin
			kind = KIND_ALLOC;
			arg  = ARG_W'(quot) + ARG_W'(1);
		end else if (req.block_offset < OFF_W'(UNIT_BYTES) || 32'(bp) >= 32'(NUNITS)) begin
			kind = KIND_IGNORE;
			arg  = '0;
		end else begin
			kind = KIND_RELEASE;
			arg  = ARG_W'(bp);
		end
	end

	assign req_stall = s1_valid_q & cmd_full;
	assign take      = req_valid & ~req_stall;
	assign cmd_valid = s1_valid_q;
	assign cmd_data  = {kind_s1, arg_s1};

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (!cmd_full) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind;
			arg_s1  <= arg;
		end
	end

endmodule

@@ hdl/fhal_queue.sv @@
// Two-entry command queue between the front end and the engine.
// Depends on fhal_pkg only for house consistency of types.
module fhal_queue import fhal_pkg::*; #(
	parameter int W = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = entry_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ hdl/fhal_engine.sv @@
// Back end: walks and updates the free list held in the header memory.
// Depends on fhal_pkg.
module fhal_engine import fhal_pkg::*; #(
	parameter int HEAP_BYTES = 16384,
	parameter int UNIT_BYTES = 8,
	parameter int ARG_W      = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	input  logic [ARG_W+1:0] cmd_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fhal_rsp_t        rsp
);

	localparam int NUNITS = HEAP_BYTES / UNIT_BYTES;
	localparam int ID_W   = $clog2(NUNITS + 1);
	localparam int AW     = $clog2(NUNITS);
	localparam int CAP    = 4 * (NUNITS + 2);
	localparam int CW     = $clog2(CAP + 1);
	localparam int SUM_W  = ARG_W + 1;
	localparam logic [ID_W-1:0] SENT = ID_W'(NUNITS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BEGIN, ST_A_START, ST_A_LINK, ST_A_CHK, ST_A_SPLIT,
		ST_R_START, ST_R_WALK, ST_R_BP, ST_R_NXT, ST_R_P, ST_FIN
	} state_t;

	// Header memory: link and size fields with separate write enables.
	logic [ID_W-1:0]  link_mem [NUNITS];
	logic [ARG_W-1:0] size_mem [NUNITS];
	logic [ID_W-1:0]  link_rd_q;
	logic [ARG_W-1:0] size_rd_q;

	state_t           state_q, nxt_state;
	fhal_kind_t       kind_q, nxt_kind;
	logic [ARG_W-1:0] arg_q, nxt_arg;
	logic [ID_W-1:0]  prev_q, nxt_prev;
	logic [ID_W-1:0]  p_q, nxt_p;
	logic [ID_W-1:0]  split_q, nxt_split;
	logic [CW-1:0]    steps_q, nxt_steps;
	logic [CW-1:0]    rsteps_q, nxt_rsteps;
	logic [ID_W-1:0]  rp_q, nxt_rp;
	logic [ARG_W-1:0] rpsize_q, nxt_rpsize;
	logic [ID_W-1:0]  rbp_q, nxt_rbp;
	logic [ID_W-1:0]  rnxt_q, nxt_rnxt;
	logic [ARG_W-1:0] bpsize_q, nxt_bpsize;
	logic [ID_W-1:0]  bplink_q, nxt_bplink;
	logic             ralloc_q, nxt_ralloc;
	logic             fin_ok_q, nxt_fin_ok;
	logic [OFF_W-1:0] fin_off_q, nxt_fin_off;
	logic [ID_W-1:0]  rover_q, nxt_rover;
	logic [ID_W-1:0]  brk_q, nxt_brk;
	logic             started_q, nxt_started;
	logic [ID_W-1:0]  sent_link_q;
	logic [ID_W-1:0]  rd_id_q;
	logic             out_valid_q;
	fhal_rsp_t        out_q;

	logic [ID_W-1:0]  rd_id;
	logic [ID_W-1:0]  wr_id;
	logic             wr_link_en;
	logic             wr_size_en;
	logic [ID_W-1:0]  wr_link;
	logic [ARG_W-1:0] wr_size;
	logic             wr_in_heap;
	logic [ID_W-1:0]  hdr_link;
	logic [ARG_W-1:0] hdr_size;
	logic [ID_W-1:0]  kb, kp, kn;
	logic [ARG_W-1:0] rem;
	logic             walk_stop;

	// Address-order key: the sentinel sits below every heap unit.
	function automatic logic [ID_W-1:0] key(input logic [ID_W-1:0] id);
		key = (id == SENT) ? '0 : id + ID_W'(1);
	endfunction

	// Payload byte offset of a block whose header sits at the given unit.
	function automatic logic [OFF_W-1:0] offset_of(input logic [ID_W-1:0] id);
		logic [31:0] prod;
		prod      = (32'(id) + 32'd1) * 32'(UNIT_BYTES);
		offset_of = prod[OFF_W-1:0];
	endfunction

	// Header read result, with the sentinel and out-of-range nodes folded in.
	always_comb begin
		if (rd_id_q == SENT) begin
			hdr_link = sent_link_q;
			hdr_size = '0;
		end else if (32'(rd_id_q) < 32'(NUNITS)) begin
			hdr_link = link_rd_q;
			hdr_size = size_rd_q;
		end else begin
			hdr_link = '0;
			hdr_size = '0;
		end
	end

	assign kb         = key(rbp_q);
	assign kp         = key(rp_q);
	assign kn         = key(hdr_link);
	assign rem        = hdr_size - arg_q;
	assign walk_stop  = (kb > kp && kb < kn) || (kp >= kn && (kb > kp || kb < kn));
	assign wr_in_heap = (32'(wr_id) < 32'(NUNITS));
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty;
	assign rsp_valid  = out_valid_q;
	assign rsp        = out_q;

	// Sequencer next-state and memory control.
	always_comb begin
		nxt_state   = state_q;
		nxt_kind    = kind_q;
		nxt_arg     = arg_q;
		nxt_prev    = prev_q;
		nxt_p       = p_q;
		nxt_split   = split_q;
		nxt_steps   = steps_q;
		nxt_rsteps  = rsteps_q;
		nxt_rp      = rp_q;
		nxt_rpsize  = rpsize_q;
		nxt_rbp     = rbp_q;
		nxt_rnxt    = rnxt_q;
		nxt_bpsize  = bpsize_q;
		nxt_bplink  = bplink_q;
		nxt_ralloc  = ralloc_q;
		nxt_fin_ok  = fin_ok_q;
		nxt_fin_off = fin_off_q;
		nxt_rover   = rover_q;
		nxt_brk     = brk_q;
		nxt_started = started_q;
		rd_id       = rd_id_q;
		wr_id       = '0;
		wr_link_en  = 1'b0;
		wr_size_en  = 1'b0;
		wr_link     = '0;
		wr_size     = '0;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					nxt_kind  = fhal_kind_t'(cmd_data[ARG_W+1:ARG_W]);
					nxt_arg   = cmd_data[ARG_W-1:0];
					nxt_state = ST_BEGIN;
				end
			end
			ST_BEGIN: begin
				// Link the sentinel to itself on first use.
				if (!started_q) begin
					wr_id       = SENT;
					wr_link_en  = 1'b1;
					wr_link     = SENT;
					nxt_rover   = SENT;
					nxt_started = 1'b1;
				end
				nxt_steps = '0;
				case (kind_q)
					KIND_ALLOC: begin
						nxt_state = ST_A_START;
					end
					KIND_RELEASE: begin
						nxt_rbp    = ID_W'(arg_q);
						nxt_ralloc = 1'b0;
						nxt_state  = ST_R_START;
					end
					default: begin
						nxt_fin_ok  = 1'b0;
						nxt_fin_off = '0;
						nxt_state   = ST_FIN;
					end
				endcase
			end
			ST_A_START: begin
				rd_id     = rover_q;
				nxt_prev  = rover_q;
				nxt_state = ST_A_LINK;
			end
			ST_A_LINK: begin
				nxt_p     = hdr_link;
				rd_id     = hdr_link;
				nxt_state = ST_A_CHK;
			end
			ST_A_CHK: begin
				if (steps_q >= CW'(CAP)) begin
					nxt_fin_ok  = 1'b0;
					nxt_fin_off = '0;
					nxt_state   = ST_FIN;
				end else if (hdr_size >= arg_q) begin
					if (hdr_size == arg_q) begin
						// Exact fit: unlink the block.
						wr_id       = prev_q;
						wr_link_en  = 1'b1;
						wr_link     = hdr_link;
						nxt_rover   = prev_q;
						nxt_fin_ok  = 1'b1;
						nxt_fin_off = offset_of(p_q);
						nxt_state   = ST_FIN;
					end else begin
						// Larger block: shrink it and hand out its tail.
						wr_id      = p_q;
						wr_size_en = 1'b1;
						wr_size    = rem;
						nxt_split  = p_q + ID_W'(rem);
						nxt_state  = ST_A_SPLIT;
					end
				end else if (p_q == rover_q) begin
					// Search wrapped: grow the break or fail.
					if (32'(brk_q) + 32'(arg_q) >= 32'(NUNITS)) begin
						nxt_fin_ok  = 1'b0;
						nxt_fin_off = '0;
						nxt_state   = ST_FIN;
					end else begin
						wr_id      = brk_q;
						wr_size_en = 1'b1;
						wr_size    = arg_q;
						nxt_brk    = brk_q + ID_W'(arg_q);
						nxt_rbp    = brk_q;
						nxt_ralloc = 1'b1;
						nxt_steps  = steps_q + CW'(1);
						nxt_state  = ST_R_START;
					end
				end else begin
					nxt_prev  = p_q;
					nxt_p     = hdr_link;
					rd_id     = hdr_link;
					nxt_steps = steps_q + CW'(1);
				end
			end
			ST_A_SPLIT: begin
				wr_id       = split_q;
				wr_size_en  = 1'b1;
				wr_size     = arg_q;
				nxt_rover   = prev_q;
				nxt_fin_ok  = 1'b1;
				nxt_fin_off = offset_of(split_q);
				nxt_state   = ST_FIN;
			end
			ST_R_START: begin
				rd_id      = rover_q;
				nxt_rp     = rover_q;
				nxt_rsteps = '0;
				nxt_state  = ST_R_WALK;
			end
			ST_R_WALK: begin
				// Find the neighbours that bracket the block by address.
				if (walk_stop) begin
					nxt_rnxt   = hdr_link;
					nxt_rpsize = hdr_size;
					rd_id      = rbp_q;
					nxt_state  = ST_R_BP;
				end else begin
					nxt_rp = hdr_link;
					if (rsteps_q + CW'(1) >= CW'(CAP)) begin
						nxt_fin_ok  = 1'b0;
						nxt_fin_off = '0;
						nxt_state   = ST_FIN;
					end else begin
						nxt_rsteps = rsteps_q + CW'(1);
						rd_id      = hdr_link;
					end
				end
			end
			ST_R_BP: begin
				nxt_bpsize = hdr_size;
				rd_id      = rnxt_q;
				nxt_state  = ST_R_NXT;
			end
			ST_R_NXT: begin
				// Merge with the upper neighbour where they touch.
				wr_id      = rbp_q;
				wr_link_en = 1'b1;
				if (SUM_W'(kb) + SUM_W'(bpsize_q) == SUM_W'(key(rnxt_q))) begin
					wr_size_en = 1'b1;
					wr_size    = bpsize_q + hdr_size;
					wr_link    = hdr_link;
					nxt_bpsize = bpsize_q + hdr_size;
					nxt_bplink = hdr_link;
				end else begin
					wr_link    = rnxt_q;
					nxt_bplink = rnxt_q;
				end
				nxt_state = ST_R_P;
			end
			ST_R_P: begin
				// Merge with the lower neighbour where they touch.
				wr_id      = rp_q;
				wr_link_en = 1'b1;
				if (SUM_W'(kp) + SUM_W'(rpsize_q) == SUM_W'(kb)) begin
					wr_size_en = 1'b1;
					wr_size    = rpsize_q + bpsize_q;
					wr_link    = bplink_q;
				end else begin
					wr_link = rbp_q;
				end
				nxt_rover = rp_q;
				if (ralloc_q) begin
					nxt_state = ST_A_START;
				end else begin
					nxt_fin_ok  = 1'b1;
					nxt_fin_off = '0;
					nxt_state   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q) begin
					nxt_state = ST_IDLE;
				end
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	// State, list registers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_IGNORE;
			arg_q       <= '0;
			prev_q      <= '0;
			p_q         <= '0;
			split_q     <= '0;
			steps_q     <= '0;
			rsteps_q    <= '0;
			rp_q        <= '0;
			rpsize_q    <= '0;
			rbp_q       <= '0;
			rnxt_q      <= '0;
			bpsize_q    <= '0;
			bplink_q    <= '0;
			ralloc_q    <= 1'b0;
			fin_ok_q    <= 1'b0;
			fin_off_q   <= '0;
			rover_q     <= '0;
			brk_q       <= '0;
			started_q   <= 1'b0;
			sent_link_q <= '0;
			rd_id_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q   <= nxt_state;
			kind_q    <= nxt_kind;
			arg_q     <= nxt_arg;
			prev_q    <= nxt_prev;
			p_q       <= nxt_p;
			split_q   <= nxt_split;
			steps_q   <= nxt_steps;
			rsteps_q  <= nxt_rsteps;
			rp_q      <= nxt_rp;
			rpsize_q  <= nxt_rpsize;
			rbp_q     <= nxt_rbp;
			rnxt_q    <= nxt_rnxt;
			bpsize_q  <= nxt_bpsize;
			bplink_q  <= nxt_bplink;
			ralloc_q  <= nxt_ralloc;
			fin_ok_q  <= nxt_fin_ok;
			fin_off_q <= nxt_fin_off;
			rover_q   <= nxt_rover;
			brk_q     <= nxt_brk;
			started_q <= nxt_started;
			rd_id_q   <= rd_id;
			if (wr_link_en && wr_id == SENT) begin
				sent_link_q <= wr_link;
			end
			if (state_q == ST_FIN && !out_valid_q) begin
				out_valid_q         <= 1'b1;
				out_q.result_offset <= fin_off_q;
				out_q.granted       <= fin_ok_q;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Header memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_link_en && wr_in_heap) begin
			link_mem[wr_id[AW-1:0]] <= wr_link;
		end
		if (wr_size_en && wr_in_heap) begin
			size_mem[wr_id[AW-1:0]] <= wr_size;
		end
		link_rd_q <= link_mem[rd_id[AW-1:0]];
		size_rd_q <= size_mem[rd_id[AW-1:0]];
	end

endmodule

@@ hdl/free_list_heap_allocator_unit.sv @@
// A request passes through the front-end register and the two-entry queue to the engine; an
// allocate walks the free list node by node (with an extra write when a block is split) and
// a release walks to its neighbours and merges them; a wrapped search adds a release walk.
// Throughput: one transaction at a time in the engine; the front end and a two-entry
// queue keep accepting while the engine works, until the queue fills.
// Reset: arst_n clears control state; header memory contents stay undefined until written.
`include "free_list_heap_allocator_unit_assert.svh"
module free_list_heap_allocator_unit import fhal_pkg::*; #(
	parameter int HEAP_BYTES = 16384,
	parameter int UNIT_BYTES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  fhal_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output fhal_rsp_t rsp
);

	localparam int NUNITS = HEAP_BYTES / UNIT_BYTES;
	localparam int ID_W   = $clog2(NUNITS + 1);
	localparam int ARG_W  = (ID_W > 12) ? ID_W : 12;

	logic             cmd_valid;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	logic [ARG_W+1:0] cmd_data;
	logic [ARG_W+1:0] q_dout;

	assign q_push = cmd_valid & ~q_full;

	// Classification front end.
	fhal_front #(
		.HEAP_BYTES(HEAP_BYTES),
		.UNIT_BYTES(UNIT_BYTES),
		.ARG_W(ARG_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd_full(q_full),
		.cmd_data(cmd_data)
	);

	// Decoupling queue.
	fhal_queue #(
		.W(ARG_W + 2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(cmd_data),
		.full(q_full),
		.pop(q_pop),
		.dout(q_dout),
		.empty(q_empty)
	);

	// List engine.
	fhal_engine #(
		.HEAP_BYTES(HEAP_BYTES),
		.UNIT_BYTES(UNIT_BYTES),
		.ARG_W(ARG_W)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(q_empty),
		.cmd_pop(q_pop),
		.cmd_data(q_dout),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// The engine never takes a command from an empty queue.
	`FHAL_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "command popped from empty queue")
	// A full queue with a pending command holds the request channel.
	`FHAL_ASSERT_IMP(a_full_stalls, q_full && cmd_valid, req_stall, "front accepted while queue full")
	// A refused transaction carries no offset.
	`FHAL_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp.granted, rsp.result_offset == '0, "offset on failure")

endmodule
